// ===== sv/ccbe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and step tables for the clamped cubic B-spline evaluator.
// No dependencies; ccbe_div, the evaluator, the checker and the testbench use this package.
package ccbe_pkg;

    localparam int MAX_KEYS_DEF = 32;
    localparam int FRAC_BITS    = 24;
    localparam int QW           = FRAC_BITS + 1;   // quotient bits, fractions up to 1.0
    localparam int DIV_STEPS    = QW;
    localparam logic [QW-1:0] ONE_Q24 = QW'(1) << FRAC_BITS;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    localparam logic [2:0] METH_EMPTY  = 3'd0;
    localparam logic [2:0] METH_SINGLE = 3'd1;
    localparam logic [2:0] METH_CLAMP  = 3'd2;
    localparam logic [2:0] METH_LINEAR = 3'd3;
    localparam logic [2:0] METH_SPLINE = 3'd4;

    typedef struct packed {
        logic               req_type;
        logic [4:0]         slot;
        logic [31:0]        key_time;
        logic signed [31:0] key_value;
        logic [31:0]        query_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] curve_value;
        logic [2:0]         method_used;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quo;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_CHK_LAST,
        ST_LIN,
        ST_U_W,
        ST_SPAN_MUL,
        ST_SPAN,
        ST_CP,
        ST_KNOT,
        ST_KNOT_W,
        ST_ALPHA,
        ST_DIV_W,
        ST_BMUL,
        ST_BADD,
        ST_OUT
    } t_state;

    // de Boor schedule: step s is (r, j) in order (1,3) (1,2) (1,1) (2,3) (2,2) (3,3).
    // Knot slots hold knots span-2 .. span+3.
    function automatic logic [1:0] step_j(input logic [2:0] s);
        logic [1:0] j;
        unique case (s)
            3'd0, 3'd3, 3'd5: j = 2'd3;
            3'd1, 3'd4:       j = 2'd2;
            default:          j = 2'd1;
        endcase
        return j;
    endfunction

    function automatic logic [2:0] step_ka(input logic [2:0] s);
        logic [2:0] q;
        unique case (s)
            3'd0, 3'd3, 3'd5: q = 3'd2;
            3'd1, 3'd4:       q = 3'd1;
            default:          q = 3'd0;
        endcase
        return q;
    endfunction

    function automatic logic [2:0] step_kb(input logic [2:0] s);
        logic [2:0] q;
        unique case (s)
            3'd0:       q = 3'd5;
            3'd1, 3'd3: q = 3'd4;
            default:    q = 3'd3;
        endcase
        return q;
    endfunction

endpackage

// ===== sv/ccbe_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccbe_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/ccbe_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: floor(num * 2^24 / den) for num <= den.
// Depends on ccbe_pkg.
module ccbe_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccbe_pkg::t_div_req i_req,
    output ccbe_pkg::t_div_rsp o_rsp
);

    localparam int CW = $clog2(ccbe_pkg::DIV_STEPS);

    logic                    r_busy;
    logic                    r_done;
    logic [CW-1:0]           r_cnt;
    logic [32:0]             r_rem;
    logic [31:0]             r_den;
    logic [ccbe_pkg::QW-1:0] r_quo;
    logic [33:0]             diff;
    logic                    ge;
    logic [31:0]             rem_sel;

    assign diff    = {1'b0, r_rem} - {2'b00, r_den};
    assign ge      = !diff[33];
    assign rem_sel = ge ? diff[31:0] : r_rem[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ccbe_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num};
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= {rem_sel, 1'b0};
            r_quo <= {r_quo[ccbe_pkg::QW-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== sv/clamped_cubic_bspline_eval.sv =====
`timescale 1ns / 1ps
// Keyframe curve evaluator: load items write a slot; evaluate items give one result.
// An evaluate item runs its divisions (up to 13) on one shared divider and its products on one multiplier.
// One item at a time: ready only when idle; the result holds until taken.
// Reset (synchronous, active low) clears the sequencer and keyframe_count; the store is not cleared.
// Depends on ccbe_pkg, ccbe_ram, ccbe_div.
module clamped_cubic_bspline_eval #(
    parameter int MAX_KEYS = ccbe_pkg::MAX_KEYS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [5:0]          i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ccbe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ccbe_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int KW = $clog2(MAX_KEYS + 1);
    localparam int IW = KW + 1;
    localparam int QW = ccbe_pkg::QW;

    ccbe_pkg::t_state   r_state, n_state;
    logic [5:0]         r_count;
    logic [31:0]        r_t, n_t;
    logic [KW-1:0]      r_k, n_k;
    logic [31:0]        r_ta, n_ta;
    logic [31:0]        r_tb, n_tb;
    logic signed [31:0] r_d [4];
    logic signed [31:0] n_d [4];
    logic [QW-1:0]      r_kn [6];
    logic [QW-1:0]      n_kn [6];
    logic [23:0]        r_u, n_u;
    logic [IW-1:0]      r_span, n_span;
    logic [2:0]         r_cnt, n_cnt;
    logic               r_lin, n_lin;
    logic [QW-1:0]      r_alpha, n_alpha;
    logic signed [31:0] r_res, n_res;
    logic [2:0]         r_meth, n_meth;
    logic signed [59:0] r_prod;

    logic               in_acc;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [63:0]        ram_rd;
    logic [31:0]        rd_time;
    logic signed [31:0] rd_val;
    logic [KW-1:0]      k_eff;
    logic signed [33:0] mul_a;
    logic signed [25:0] mul_b;
    ccbe_pkg::t_div_req div_req;
    ccbe_pkg::t_div_rsp div_rsp;

    logic [31:0]        pt, nt;
    logic signed [31:0] pv, nv;
    logic [59:0]        pm1;
    logic [KW-1:0]      m_span, m_cap;
    logic [IW-1:0]      kidx;
    logic [QW-1:0]      ka, kb;
    logic [1:0]         bj, bjm;
    logic signed [59:0] rsum;
    logic signed [35:0] rq;
    logic signed [36:0] bsum;
    logic signed [31:0] bsat;

    assign in_acc  = i_in_valid && o_in_ready;
    assign ram_we  = in_acc && (i_in_item.req_type == ccbe_pkg::REQ_LOAD)
                     && (32'(i_in_item.slot) < 32'(MAX_KEYS));
    assign rd_time = ram_rd[63:32];
    assign rd_val  = signed'(ram_rd[31:0]);
    assign k_eff   = (32'(r_count) > 32'(MAX_KEYS)) ? KW'(MAX_KEYS) : KW'(r_count);

    ccbe_ram #(
        .WIDTH (64),
        .DEPTH (MAX_KEYS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (AW'(i_in_item.slot)),
        .i_wr_data ({i_in_item.key_time, i_in_item.key_value}),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rd)
    );

    ccbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccbe_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_k     <= n_k;
        r_ta    <= n_ta;
        r_tb    <= n_tb;
        r_d     <= n_d;
        r_kn    <= n_kn;
        r_u     <= n_u;
        r_span  <= n_span;
        r_cnt   <= n_cnt;
        r_lin   <= n_lin;
        r_alpha <= n_alpha;
        r_res   <= n_res;
        r_meth  <= n_meth;
        r_prod  <= mul_a * mul_b;
    end

    // Blend datapath: d[j] = d[j-1] + round((d[j] - d[j-1]) * alpha / 2^24)
    always_comb begin
        bj   = r_lin ? 2'd3 : ccbe_pkg::step_j(r_cnt);
        bjm  = bj - 2'd1;
        rsum = r_prod + 60'sd8388608;
        rq   = 36'(rsum >>> ccbe_pkg::FRAC_BITS);
        bsum = 37'(rq) + 37'(r_d[bjm]);
        if (bsum > 37'sd2147483647) begin
            bsat = 32'sh7FFFFFFF;
        end else if (bsum < -37'sd2147483648) begin
            bsat = 32'sh80000000;
        end else begin
            bsat = 32'(bsum);
        end
    end

    always_comb begin
        n_state = r_state;
        n_t     = r_t;
        n_k     = r_k;
        n_ta    = r_ta;
        n_tb    = r_tb;
        n_d     = r_d;
        n_kn    = r_kn;
        n_u     = r_u;
        n_span  = r_span;
        n_cnt   = r_cnt;
        n_lin   = r_lin;
        n_alpha = r_alpha;
        n_res   = r_res;
        n_meth  = r_meth;
        div_req = '0;
        ram_raddr = '0;
        mul_a   = '0;
        mul_b   = '0;

        // linear neighbours, valid in ST_LIN
        if (rd_time >= r_t) begin
            pt = r_ta;
            pv = r_d[2];
            nt = rd_time;
            nv = rd_val;
        end else begin
            pt = rd_time;
            pv = rd_val;
            nt = r_tb;
            nv = r_d[3];
        end

        pm1    = unsigned'(r_prod) - 60'd1;
        m_span = pm1[ccbe_pkg::FRAC_BITS +: KW];
        m_cap  = r_k - KW'(4);
        kidx   = r_span - IW'(2) + IW'(r_cnt);
        ka     = r_kn[ccbe_pkg::step_ka(r_cnt)];
        kb     = r_kn[ccbe_pkg::step_kb(r_cnt)];

        unique case (r_state)
            ccbe_pkg::ST_IDLE: begin
                if (in_acc && (i_in_item.req_type == ccbe_pkg::REQ_EVAL)) begin
                    n_t = i_in_item.query_time;
                    n_k = k_eff;
                    if (k_eff == '0) begin
                        n_res   = '0;
                        n_meth  = ccbe_pkg::METH_EMPTY;
                        n_state = ccbe_pkg::ST_OUT;
                    end else begin
                        n_state = ccbe_pkg::ST_RD_FIRST;
                    end
                end
            end
            ccbe_pkg::ST_RD_FIRST: begin
                n_state = ccbe_pkg::ST_RD_LAST;
            end
            ccbe_pkg::ST_RD_LAST: begin
                ram_raddr = AW'(r_k - KW'(1));
                n_ta      = rd_time;
                n_d[2]    = rd_val;
                if (r_k == KW'(1)) begin
                    n_res   = rd_val;
                    n_meth  = ccbe_pkg::METH_SINGLE;
                    n_state = ccbe_pkg::ST_OUT;
                end else if (r_t <= rd_time) begin
                    n_res   = rd_val;
                    n_meth  = ccbe_pkg::METH_CLAMP;
                    n_state = ccbe_pkg::ST_OUT;
                end else begin
                    n_state = ccbe_pkg::ST_CHK_LAST;
                end
            end
            ccbe_pkg::ST_CHK_LAST: begin
                ram_raddr = AW'(1);
                n_tb      = rd_time;
                n_d[3]    = rd_val;
                if (r_t >= rd_time) begin
                    n_res   = rd_val;
                    n_meth  = ccbe_pkg::METH_CLAMP;
                    n_state = ccbe_pkg::ST_OUT;
                end else if (r_k < KW'(4)) begin
                    n_state = ccbe_pkg::ST_LIN;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = r_t - r_ta;
                    div_req.den   = rd_time - r_ta;
                    n_state       = ccbe_pkg::ST_U_W;
                end
            end
            ccbe_pkg::ST_LIN: begin
                n_d[2] = pv;
                n_d[3] = nv;
                if (nt <= pt) begin
                    n_res   = pv;
                    n_meth  = ccbe_pkg::METH_LINEAR;
                    n_state = ccbe_pkg::ST_OUT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = r_t - pt;
                    div_req.den   = nt - pt;
                    n_lin         = 1'b1;
                    n_state       = ccbe_pkg::ST_DIV_W;
                end
            end
            ccbe_pkg::ST_U_W: begin
                if (div_rsp.done) begin
                    n_u     = div_rsp.quo[23:0];
                    n_state = ccbe_pkg::ST_SPAN_MUL;
                end
            end
            ccbe_pkg::ST_SPAN_MUL: begin
                // (u + 1) * (k - 3) locates the span without a knot search
                mul_a   = 34'(r_u) + 34'sd1;
                mul_b   = 26'(r_k - KW'(3));
                n_state = ccbe_pkg::ST_SPAN;
            end
            ccbe_pkg::ST_SPAN: begin
                n_span  = IW'(3) + IW'((m_span < m_cap) ? m_span : m_cap);
                n_cnt   = '0;
                n_state = ccbe_pkg::ST_CP;
            end
            ccbe_pkg::ST_CP: begin
                ram_raddr = AW'(r_span - IW'(3) + IW'(r_cnt));
                if (r_cnt != '0) begin
                    n_d[2'(r_cnt - 3'd1)] = rd_val;
                end
                if (r_cnt == 3'd4) begin
                    n_cnt   = '0;
                    n_state = ccbe_pkg::ST_KNOT;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            ccbe_pkg::ST_KNOT: begin
                if (kidx <= IW'(3) || kidx >= IW'(r_k)) begin
                    n_kn[r_cnt] = (kidx <= IW'(3)) ? '0 : ccbe_pkg::ONE_Q24;
                    if (r_cnt == 3'd5) begin
                        n_cnt   = '0;
                        n_lin   = 1'b0;
                        n_state = ccbe_pkg::ST_ALPHA;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = 32'(kidx - IW'(3));
                    div_req.den   = 32'(r_k - KW'(3));
                    n_state       = ccbe_pkg::ST_KNOT_W;
                end
            end
            ccbe_pkg::ST_KNOT_W: begin
                if (div_rsp.done) begin
                    n_kn[r_cnt] = div_rsp.quo;
                    if (r_cnt == 3'd5) begin
                        n_cnt   = '0;
                        n_lin   = 1'b0;
                        n_state = ccbe_pkg::ST_ALPHA;
                    end else begin
                        n_cnt   = r_cnt + 3'd1;
                        n_state = ccbe_pkg::ST_KNOT;
                    end
                end
            end
            ccbe_pkg::ST_ALPHA: begin
                div_req.start = 1'b1;
                div_req.num   = 32'(r_u) - 32'(ka);
                div_req.den   = 32'(kb - ka);
                n_state       = ccbe_pkg::ST_DIV_W;
            end
            ccbe_pkg::ST_DIV_W: begin
                if (div_rsp.done) begin
                    n_alpha = div_rsp.quo;
                    n_state = ccbe_pkg::ST_BMUL;
                end
            end
            ccbe_pkg::ST_BMUL: begin
                mul_a   = 34'(r_d[bj]) - 34'(r_d[bjm]);
                mul_b   = 26'(r_alpha);
                n_state = ccbe_pkg::ST_BADD;
            end
            ccbe_pkg::ST_BADD: begin
                n_d[bj] = bsat;
                if (r_lin || r_cnt == 3'd5) begin
                    n_res   = bsat;
                    n_meth  = r_lin ? ccbe_pkg::METH_LINEAR : ccbe_pkg::METH_SPLINE;
                    n_state = ccbe_pkg::ST_OUT;
                end else begin
                    n_cnt   = r_cnt + 3'd1;
                    n_state = ccbe_pkg::ST_ALPHA;
                end
            end
            ccbe_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ccbe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ccbe_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready             = (r_state == ccbe_pkg::ST_IDLE);
    assign o_out_valid            = (r_state == ccbe_pkg::ST_OUT);
    assign o_out_item.curve_value = r_res;
    assign o_out_item.method_used = r_meth;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_span_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ccbe_pkg::ST_CP) |-> (r_span >= IW'(3) && r_span <= IW'(r_k - KW'(1))))
        else $error("span outside [3, k-1]");

    a_alpha_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ccbe_pkg::ST_BMUL && !r_lin) |-> (r_alpha < ccbe_pkg::ONE_Q24))
        else $error("de Boor alpha not below one");

    a_spline_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.method_used == ccbe_pkg::METH_SPLINE) |-> (r_k >= KW'(4)))
        else $error("spline result with fewer than four keyframes");

endmodule

// ===== test/ccbe_checker.sv =====
`timescale 1ns / 1ps
// Checker for the keyframe curve evaluator: watches the config port and both item channels,
// predicts each evaluate result from its own keyframe table, and compares. Depends on ccbe_pkg.
module ccbe_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [5:0]          i_cfg_wr_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  ccbe_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  ccbe_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic [31:0] Q24_ONE = 32'h0100_0000;

    logic [31:0]         key_t [ccbe_pkg::MAX_KEYS_DEF];
    logic signed [31:0]  key_v [ccbe_pkg::MAX_KEYS_DEF];
    logic [5:0]          kf_count;
    ccbe_pkg::t_out_item curve_q[$];

    function automatic logic [31:0] frac_q24(input logic [63:0] num, input logic [63:0] den);
        if (den == 64'd0) return 32'd0;
        return 32'((num << 24) / den);
    endfunction

    function automatic logic [31:0] knot_q24(input int unsigned idx, input int unsigned k);
        if (idx <= 3) return 32'd0;
        if (idx >= k) return Q24_ONE;
        return frac_q24(64'(idx - 3), 64'(k - 3));
    endfunction

    // a + round((b - a) * alpha / 2^24), ties toward plus infinity
    function automatic longint blend_q24(input longint a, input longint b,
                                         input logic [31:0] alpha);
        longint p;
        p = (b - a) * longint'({32'd0, alpha});
        return a + ((p + 64'sd8388608) >>> 24);
    endfunction

    function automatic longint spline_value(input int unsigned k, input logic [31:0] u);
        int unsigned span;
        int unsigned ii;
        logic [31:0] ka, kb, alpha;
        longint d[4];
        span = 3;
        for (int unsigned i = 4; i <= k - 1; i++)
            if (knot_q24(i, k) <= u) span = i;
        for (int j = 0; j < 4; j++) d[j] = key_v[(span - 3 + j) % ccbe_pkg::MAX_KEYS_DEF];
        for (int r = 1; r <= 3; r++) begin
            for (int j = 3; j >= r; j--) begin
                ii    = span - 3 + j;
                ka    = knot_q24(ii, k);
                kb    = knot_q24(ii + 4 - r, k);
                alpha = 32'd0;
                if (kb > ka && u >= ka) alpha = frac_q24(64'(u - ka), 64'(kb - ka));
                d[j] = blend_q24(d[j-1], d[j], alpha);
            end
        end
        return d[3];
    endfunction

    function automatic ccbe_pkg::t_out_item predict_curve(input logic [31:0] qt);
        ccbe_pkg::t_out_item res;
        int unsigned k, last, idx;
        logic [31:0] t0, dt, alpha, u;
        longint      v;
        k = (kf_count > ccbe_pkg::MAX_KEYS_DEF) ? ccbe_pkg::MAX_KEYS_DEF : kf_count;
        v = 0;
        if (k == 0) begin
            res.method_used = ccbe_pkg::METH_EMPTY;
        end else if (k == 1) begin
            v = key_v[0];
            res.method_used = ccbe_pkg::METH_SINGLE;
        end else begin
            last = k - 1;
            if (qt <= key_t[0]) begin
                v = key_v[0];
                res.method_used = ccbe_pkg::METH_CLAMP;
            end else if (qt >= key_t[last]) begin
                v = key_v[last];
                res.method_used = ccbe_pkg::METH_CLAMP;
            end else if (k < 4) begin
                res.method_used = ccbe_pkg::METH_LINEAR;
                idx = last;
                for (int unsigned i = k; i > 0; i--)
                    if (key_t[i-1] >= qt) idx = i - 1;
                if (idx == 0) idx = 1;
                if (key_t[idx] <= key_t[idx-1]) begin
                    v = key_v[idx-1];
                end else begin
                    t0    = key_t[idx-1];
                    dt    = (qt > t0) ? qt - t0 : 32'd0;
                    alpha = frac_q24(64'(dt), 64'(key_t[idx] - t0));
                    if (alpha > Q24_ONE) alpha = Q24_ONE;
                    v = blend_q24(key_v[idx-1], key_v[idx], alpha);
                end
            end else begin
                u = frac_q24(64'(qt - key_t[0]), 64'(key_t[last] - key_t[0]));
                if (u >= Q24_ONE) u = Q24_ONE - 1;
                v = spline_value(k, u);
                res.method_used = ccbe_pkg::METH_SPLINE;
            end
        end
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        res.curve_value = 32'(v);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        ccbe_pkg::t_out_item exp_item;
        if (!i_rst_n) begin
            kf_count = '0;
            curve_q.delete();
        end else begin
            if (i_cfg_wr_en) kf_count = i_cfg_wr_data;
            if (i_out_valid && i_out_ready) begin
                if (curve_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: value %h method %0d",
                                              i_out_item.curve_value, i_out_item.method_used));
                end else begin
                    exp_item = curve_q.pop_front();
                    if (i_out_item.curve_value !== exp_item.curve_value)
                        report_mismatch($sformatf("curve_value %h, expected %h",
                                                  i_out_item.curve_value, exp_item.curve_value));
                    if (i_out_item.method_used !== exp_item.method_used)
                        report_mismatch($sformatf("method_used %0d, expected %0d",
                                                  i_out_item.method_used, exp_item.method_used));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_item.req_type == ccbe_pkg::REQ_LOAD) begin
                    if (i_in_item.slot < ccbe_pkg::MAX_KEYS_DEF) begin
                        key_t[i_in_item.slot] = i_in_item.key_time;
                        key_v[i_in_item.slot] = i_in_item.key_value;
                    end
                end else begin
                    curve_q.push_back(predict_curve(i_in_item.query_time));
                end
            end
        end
        o_pending = curve_q.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, keyframe loads and evaluate items, receiver stalls
// and the verdict. Depends on ccbe_pkg, ccbe_checker and the evaluator RTL.
module tb;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [5:0]          cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    ccbe_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    ccbe_pkg::t_out_item out_item;
    int                  fail_count;
    int                  pending;

    logic [31:0] tb_times [32];
    int          items_sent = 0;
    int          burst_left = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stall_mode = 0;
    int          mode_left = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    clamped_cubic_bspline_eval u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_item    (in_item),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_item   (out_item)
    );

    ccbe_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: long hold on request, otherwise a stall pattern that changes mode now and then
    always @(negedge clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = 3000;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(64, 400);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            out_ready = 1'b0;
        end else begin
            case (stall_mode)
                0:       out_ready = 1'b1;
                1:       out_ready = ($urandom_range(0, 1) == 0);
                2:       out_ready = ($urandom_range(0, 7) == 0);
                default: out_ready = ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic send_item(input ccbe_pkg::t_in_item it);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge clk); while (!(in_valid && in_ready));
        items_sent++;
    endtask

    task automatic load_key(input int s, input logic [31:0] t, input logic [31:0] v);
        ccbe_pkg::t_in_item it;
        it = '0;
        it.req_type  = ccbe_pkg::REQ_LOAD;
        it.slot      = 5'(s);
        it.key_time  = t;
        it.key_value = v;
        it.query_time = $urandom();
        tb_times[s] = t;
        send_item(it);
    endtask

    task automatic eval_at(input logic [31:0] q);
        ccbe_pkg::t_in_item it;
        it = '0;
        it.req_type   = ccbe_pkg::REQ_EVAL;
        it.slot       = 5'($urandom());
        it.key_time   = $urandom();
        it.key_value  = $urandom();
        it.query_time = q;
        send_item(it);
    endtask

    // Drop valid and wait until every expected result is back, plus room for a trailing load
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_key_count(input logic [5:0] n);
        drain();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = n;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic fill_table();
        logic [31:0] t, step;
        int          style;
        style = $urandom_range(0, 3);
        t = (style == 0) ? 32'd0 : $urandom_range(0, 32'h7fff_ffff);
        for (int s = 0; s < 32; s++) begin
            logic [31:0] v;
            case ($urandom_range(0, 5))
                0:       v = 32'h7fff_ffff;
                1:       v = 32'h8000_0000;
                2:       v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                default: v = $urandom();
            endcase
            load_key(s, t, v);
            case (style)
                0:       step = (s == 30) ? 32'hffff_ffff - t : 32'h0800_0000;
                1:       step = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 1000);
                2:       step = $urandom_range(1, 32'h0400_0000);
                default: step = $urandom_range(0, 32'h0100_0000);
            endcase
            if (32'hffff_ffff - t < step) step = 32'hffff_ffff - t;
            t = t + step;
        end
    endtask

    function automatic logic [31:0] pick_query(input int k);
        int a;
        int hi;
        hi = (k > 32) ? 31 : ((k < 1) ? 0 : k - 1);
        a  = $urandom_range(0, hi);
        case ($urandom_range(0, 7))
            0:       return tb_times[a];
            1:       return tb_times[0] - $urandom_range(0, 5);
            2:       return tb_times[hi] + $urandom_range(0, 5);
            3:       return $urandom();
            default: begin
                if (a < hi && tb_times[a+1] > tb_times[a])
                    return tb_times[a] + $urandom_range(0, tb_times[a+1] - tb_times[a]);
                return tb_times[a] + $urandom_range(0, 3);
            end
        endcase
    endfunction

    initial begin
        int phase;
        int kc;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty, single, clamp at both ends, linear, spline at extreme values
        set_key_count(6'd0);
        eval_at(32'd0);
        eval_at(32'hffff_ffff);
        load_key(0, 32'd1000, 32'h7fff_ffff);
        set_key_count(6'd1);
        eval_at(32'd5);
        load_key(1, 32'd2000, 32'h8000_0000);
        load_key(2, 32'd2000, 32'h0001_0000);
        load_key(3, 32'hffff_ffff, 32'hffff_0000);
        set_key_count(6'd2);
        eval_at(32'd1000);
        eval_at(32'd2000);
        eval_at(32'd1500);
        set_key_count(6'd3);
        eval_at(32'd1999);
        eval_at(32'd1001);
        eval_at(32'd2000);
        set_key_count(6'd4);
        eval_at(32'd1500);
        eval_at(32'd3000000000);
        eval_at(32'hffff_fffe);

        phase = 0;
        while (items_sent < 450) begin
            if (phase == 0 || $urandom_range(0, 1) == 0) fill_table();
            case ($urandom_range(0, 10))
                0:       kc = 0;
                1:       kc = 1;
                2:       kc = 2;
                3:       kc = 3;
                4:       kc = 4;
                5:       kc = 5;
                6:       kc = 32;
                7:       kc = 63;
                8:       kc = $urandom_range(33, 63);
                default: kc = $urandom_range(4, 31);
            endcase
            set_key_count(6'(kc));
            if (phase == 1) hold_reqs++;
            repeat ($urandom_range(10, 30)) begin
                if ($urandom_range(0, 11) == 0)
                    load_key($urandom_range(0, 31), $urandom(), $urandom());
                else
                    eval_at(pick_query(kc));
                if (phase == 3 && $urandom_range(0, 7) == 0) drain();
            end
            phase++;
        end

        drain();
        repeat (500) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #40ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ccbe_pkg.sv
sv/ccbe_ram.sv
sv/ccbe_div.sv
sv/clamped_cubic_bspline_eval.sv
test/ccbe_checker.sv
test/tb.sv
